[design/bfba_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Best-fit block allocator package
// Shared field widths, codes and the structs passed between the controller
// and the table cells.
// ----------------------------------------------------------------------------
package bfba_pkg;

  localparam int unsigned DATA_W  = 17;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned NEED_W  = 18;

  // Pool size after reset.
  localparam logic [DATA_W-1:0] RESET_POOL = 17'd65536;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_REALLOC = 2'd2,
    FN_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_NULL       = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_INIT  = 3'd1,
    CMD_UPD   = 3'd2,
    CMD_MERGE = 3'd3,
    CMD_SPLIT = 3'd4
  } cmd_kind_e;

  // One table entry.
  typedef struct packed {
    logic [DATA_W-1:0]  off;
    logic [DATA_W-1:0]  bytes;
    logic               free;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Table command broadcast to every cell; val is the split size or the pool size.
  typedef struct packed {
    cmd_kind_e          kind;
    logic               free_en;
    logic               free_val;
    logic               stamp_en;
    logic [STAMP_W-1:0] stamp;
    logic [DATA_W-1:0]  val;
  } cmd_t;

  // Search token that walks down the cell chain one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               mode_off;
    logic [DATA_W-1:0]  target;
    logic [NEED_W-1:0]  need;
    logic               hit;
    logic               hit_free;
    logic [DATA_W-1:0]  hit_bytes;
    logic [DATA_W-1:0]  hit_off;
    logic               hit_prev_free;
    logic               nxt_pend;
    logic               nxt_valid;
    logic               nxt_free;
    logic [DATA_W-1:0]  nxt_bytes;
    logic               best;
    logic [DATA_W-1:0]  best_bytes;
    logic [STAMP_W-1:0] best_stamp;
    logic [DATA_W-1:0]  best_off;
    logic               last_free;
  } tok_t;

endpackage
`default_nettype wire

[design/bfba_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator table cell
// Holds one table entry, applies broadcast insert/remove/update commands by
// loading from its neighbors, and advances the search token by one cell.
// ----------------------------------------------------------------------------
module bfba_cell #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned IDX          = 0,
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfba_pkg::cmd_t       cmd_i,
  input  logic [IDX_W-1:0]     cmd_idx_i,
  input  logic [CNT_W-1:0]     count_i,
  input  bfba_pkg::entry_t     left_i,
  input  bfba_pkg::entry_t     right_i,
  output bfba_pkg::entry_t     entry_o,
  input  bfba_pkg::tok_t       tok_i,
  input  logic [IDX_W-1:0]     tok_hit_idx_i,
  input  logic [IDX_W-1:0]     tok_best_idx_i,
  output bfba_pkg::tok_t       tok_o,
  output logic [IDX_W-1:0]     tok_hit_idx_o,
  output logic [IDX_W-1:0]     tok_best_idx_o
);
  import bfba_pkg::*;

  localparam logic [IDX_W:0]    MY   = (IDX_W+1)'(IDX);
  localparam logic [DATA_W-1:0] HDR  = DATA_W'(HEADER_BYTES);

  entry_t            entry_q, entry_d;
  tok_t              tok_q, tok_d;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d, best_idx_q, best_idx_d;
  logic [IDX_W:0]    idx_w, idx_p1;
  logic              is_valid, match, cand;
  logic [DATA_W-1:0] hdr_addr;

  assign idx_w    = {1'b0, cmd_idx_i};
  assign idx_p1   = idx_w + 1'b1;
  assign is_valid = MY < (IDX_W+1)'(count_i);
  assign hdr_addr = entry_q.off + HDR;

  // Table update from the broadcast command.
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.kind)
      CMD_INIT: begin
        entry_d.off   = '0;
        entry_d.bytes = (IDX == 0) ? cmd_i.val : '0;
        entry_d.free  = (IDX == 0);
        entry_d.stamp = '0;
      end
      CMD_UPD: begin
        if (MY == idx_w) begin
          if (cmd_i.free_en)  entry_d.free  = cmd_i.free_val;
          if (cmd_i.stamp_en) entry_d.stamp = cmd_i.stamp;
        end
      end
      CMD_MERGE: begin
        if (MY == idx_w) begin
          entry_d.bytes = entry_q.bytes + right_i.bytes;
          if (cmd_i.free_en)  entry_d.free  = cmd_i.free_val;
          if (cmd_i.stamp_en) entry_d.stamp = cmd_i.stamp;
        end else if (MY > idx_w) begin
          entry_d = right_i;
        end
      end
      CMD_SPLIT: begin
        if (MY == idx_w) begin
          entry_d.bytes = cmd_i.val;
          if (cmd_i.free_en) entry_d.free = cmd_i.free_val;
        end else if (MY == idx_p1) begin
          entry_d.off   = left_i.off + cmd_i.val;
          entry_d.bytes = left_i.bytes - cmd_i.val;
          entry_d.free  = 1'b1;
          entry_d.stamp = cmd_i.stamp;
        end else if (MY > idx_p1) begin
          entry_d = left_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  // Search step: handle match with neighbor capture, and best-fit compare.
  always_comb begin
    tok_d      = tok_i;
    hit_idx_d  = tok_hit_idx_i;
    best_idx_d = tok_best_idx_i;
    match = is_valid && (tok_i.mode_off ? (entry_q.off == tok_i.target)
                                        : (hdr_addr == tok_i.target));
    cand  = is_valid && entry_q.free && ({1'b0, entry_q.bytes} >= tok_i.need);
    if (tok_i.nxt_pend) begin
      tok_d.nxt_pend  = 1'b0;
      tok_d.nxt_valid = is_valid;
      tok_d.nxt_free  = entry_q.free;
      tok_d.nxt_bytes = entry_q.bytes;
    end
    if (!tok_i.hit && match) begin
      tok_d.hit           = 1'b1;
      tok_d.hit_free      = entry_q.free;
      tok_d.hit_bytes     = entry_q.bytes;
      tok_d.hit_off       = entry_q.off;
      tok_d.hit_prev_free = tok_i.last_free;
      tok_d.nxt_pend      = 1'b1;
      hit_idx_d           = MY[IDX_W-1:0];
    end
    if (cand && (!tok_i.best || (entry_q.bytes < tok_i.best_bytes) ||
                 ((entry_q.bytes == tok_i.best_bytes) &&
                  (entry_q.stamp > tok_i.best_stamp)))) begin
      tok_d.best       = 1'b1;
      tok_d.best_bytes = entry_q.bytes;
      tok_d.best_stamp = entry_q.stamp;
      tok_d.best_off   = entry_q.off;
      best_idx_d       = MY[IDX_W-1:0];
    end
    tok_d.last_free = entry_q.free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q.off   <= '0;
      entry_q.bytes <= (IDX == 0) ? RESET_POOL : '0;
      entry_q.free  <= (IDX == 0);
      entry_q.stamp <= '0;
      tok_q         <= '0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    best_idx_q <= best_idx_d;
  end

  assign entry_o        = entry_q;
  assign tok_o          = tok_q;
  assign tok_hit_idx_o  = hit_idx_q;
  assign tok_best_idx_o = best_idx_q;

endmodule
`default_nettype wire

[design/best_fit_block_allocator.sv]
// Requests other than the unused code are searched by a token that walks the cell chain
// one cell per cycle. One request is in work at a time; the next is accepted while the
// previous result waits in the output register.
// Reset: asynchronous, active low; the pool comes up as one free block of 65536 bytes.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Best-fit block allocator
// Controller and cell chain for an address-ordered block table with
// best-fit allocation, coalescing free and in-place or moving reallocation.
// ----------------------------------------------------------------------------
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned ALIGN_BYTES  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] pool_bytes_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [16:0] request_bytes_i,
  input  logic [16:0] handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [16:0] address_o,
  output logic        moved_o,
  output logic [16:0] copy_bytes_o
);
  import bfba_pkg::*;

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  // Reciprocal for the rounding quotient; exact for every dividend below 2**NEED_W.
  localparam int unsigned RND_S  = NEED_W + $clog2(ALIGN_BYTES);
  localparam int unsigned PROD_W = NEED_W + RND_S + 1;
  localparam logic [RND_S:0] RND_M =
    (RND_S+1)'(((64'd1 << RND_S) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
  localparam logic [DATA_W-1:0] HDR      = DATA_W'(HEADER_BYTES);
  localparam logic [DATA_W-1:0] MIN_TAIL = DATA_W'(HEADER_BYTES + ALIGN_BYTES);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_BLOCKS);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RND  = 14'b00000000000010,
    S_INJ  = 14'b00000000000100,
    S_SCAN = 14'b00000000001000,
    S_DEC  = 14'b00000000010000,
    S_ALC  = 14'b00000000100000,
    S_FR1  = 14'b00000001000000,
    S_FR2  = 14'b00000010000000,
    S_FR3  = 14'b00000100000000,
    S_RA1  = 14'b00001000000000,
    S_RA2  = 14'b00010000000000,
    S_RB1  = 14'b00100000000000,
    S_RB2  = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_e;

  state_e              state_q, state_d;
  func_e               func_q, func_d;
  logic [DATA_W-1:0]   req_q, req_d, h_q, h_d, old_off_q, old_off_d;
  logic [NEED_W-1:0]   rnd_x, rnd_q_q, rnd_q_d;
  logic [PROD_W-1:0]   rnd_prod;
  logic [NEED_W-1:0]   need_q, need_d, need_calc;
  tok_t                res_q, res_d;
  logic [IDX_W-1:0]    res_hit_q, res_hit_d, res_best_q, res_best_d, idx_q, idx_d;
  logic                rescan_q, rescan_d;
  status_e             st_q, st_d, out_st_q;
  logic [DATA_W-1:0]   addr_q, addr_d, copy_q, copy_d, out_addr_q, out_copy_q;
  logic                moved_q, moved_d, out_moved_q;
  logic                out_valid_q, out_valid_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [STAMP_W-1:0]  stamp_q, stamp_d;
  cmd_t                cmd;
  logic [IDX_W-1:0]    cmd_idx;
  tok_t                inj_tok;
  logic [DATA_W-1:0]   left_bytes, sum17, old_pay;
  logic                split_ok;

  entry_t              entries [MAX_BLOCKS];
  tok_t                toks    [MAX_BLOCKS+1];
  logic [IDX_W-1:0]    hit_idx [MAX_BLOCKS+1];
  logic [IDX_W-1:0]    best_idx[MAX_BLOCKS+1];

  // Cell chain.
  assign toks[0]     = inj_tok;
  assign hit_idx[0]  = '0;
  assign best_idx[0] = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    entry_t left_e, right_e;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid_l
      assign left_e = entries[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = entries[g+1];
    end
    bfba_cell #(
      .MAX_BLOCKS  (MAX_BLOCKS),
      .HEADER_BYTES(HEADER_BYTES),
      .IDX         (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .cmd_idx_i      (cmd_idx),
      .count_i        (count_q),
      .left_i         (left_e),
      .right_i        (right_e),
      .entry_o        (entries[g]),
      .tok_i          (toks[g]),
      .tok_hit_idx_i  (hit_idx[g]),
      .tok_best_idx_i (best_idx[g]),
      .tok_o          (toks[g+1]),
      .tok_hit_idx_o  (hit_idx[g+1]),
      .tok_best_idx_o (best_idx[g+1])
    );
  end

  // Request rounded up to the alignment by a reciprocal multiply, plus header.
  assign rnd_x     = {1'b0, req_q} + NEED_W'(ALIGN_BYTES - 1);
  assign rnd_prod  = PROD_W'(rnd_x) * PROD_W'(RND_M);
  assign need_calc = NEED_W'(HEADER_BYTES) + rnd_q_q * NEED_W'(ALIGN_BYTES);

  // Helper values for split decisions and copy length.
  assign sum17   = res_q.hit_bytes + res_q.nxt_bytes;
  assign old_pay = res_q.hit_bytes - HDR;

  always_comb begin
    inj_tok          = '0;
    inj_tok.vld      = (state_q == S_INJ);
    inj_tok.mode_off = rescan_q;
    inj_tok.target   = rescan_q ? old_off_q : h_q;
    inj_tok.need     = need_calc;
  end

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);

  // Controller.
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    req_d       = req_q;
    h_d         = h_q;
    rnd_q_d     = rnd_q_q;
    need_d      = need_q;
    res_d       = res_q;
    res_hit_d   = res_hit_q;
    res_best_d  = res_best_q;
    idx_d       = idx_q;
    rescan_d    = rescan_q;
    old_off_d   = old_off_q;
    st_d        = st_q;
    addr_d      = addr_q;
    moved_d     = moved_q;
    copy_d      = copy_q;
    count_d     = count_q;
    stamp_d     = stamp_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd         = '0;
    cmd.kind    = CMD_NONE;
    cmd_idx     = idx_q;
    left_bytes  = '0;
    split_ok    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          cmd.kind = CMD_INIT;
          cmd.val  = pool_bytes_i;
          count_d  = CNT_W'(1);
          stamp_d  = STAMP_W'(1);
        end else if (in_valid_i) begin
          func_d   = func_e'(func_i);
          req_d    = request_bytes_i;
          h_d      = handle_i;
          rescan_d = 1'b0;
          st_d     = ST_OK;
          addr_d   = '0;
          moved_d  = 1'b0;
          copy_d   = '0;
          state_d  = (func_e'(func_i) == FN_NONE) ? S_DONE : S_RND;
        end
      end
      // Register the rounding quotient from the reciprocal multiply.
      S_RND: begin
        rnd_q_d = rnd_prod[RND_S +: NEED_W];
        state_d = S_INJ;
      end
      S_INJ: begin
        need_d  = need_calc;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (toks[MAX_BLOCKS].vld) begin
          res_d      = toks[MAX_BLOCKS];
          res_hit_d  = hit_idx[MAX_BLOCKS];
          res_best_d = best_idx[MAX_BLOCKS];
          state_d    = S_DEC;
        end
      end
      S_DEC: begin
        idx_d = res_hit_q;
        if (rescan_q) begin
          state_d = S_FR1;
        end else if (func_q == FN_ALLOC) begin
          if (res_q.best) begin
            state_d = S_ALC;
          end else begin
            st_d    = ST_NO_FIT;
            state_d = S_DONE;
          end
        end else if (h_q == '0) begin
          st_d    = ST_NULL;
          state_d = S_DONE;
        end else if (!res_q.hit || res_q.hit_free) begin
          st_d    = ST_BAD_HANDLE;
          state_d = S_DONE;
        end else if (func_q == FN_FREE) begin
          state_d = S_FR1;
        end else if ({1'b0, res_q.hit_bytes} >= need_q) begin
          addr_d  = h_q;
          state_d = S_RA1;
        end else if (res_q.nxt_valid && res_q.nxt_free &&
                     (({1'b0, res_q.hit_bytes} + {1'b0, res_q.nxt_bytes}) >= need_q)) begin
          addr_d  = h_q;
          state_d = S_RB1;
        end else if (res_q.best) begin
          state_d = S_ALC;
        end else begin
          st_d    = ST_NO_FIT;
          state_d = S_DONE;
        end
      end
      // Take the best block; split off a free tail if large enough and the table has room.
      S_ALC: begin
        left_bytes   = res_q.best_bytes - need_q[DATA_W-1:0];
        split_ok     = (left_bytes >= MIN_TAIL) && (count_q < CNT_MAX);
        cmd.kind     = split_ok ? CMD_SPLIT : CMD_UPD;
        cmd_idx      = res_best_q;
        cmd.free_en  = 1'b1;
        cmd.free_val = 1'b0;
        cmd.stamp    = stamp_q;
        cmd.val      = need_q[DATA_W-1:0];
        if (split_ok) begin
          stamp_d = stamp_q + 1'b1;
          count_d = count_q + 1'b1;
        end
        addr_d = res_q.best_off + HDR;
        if (func_q == FN_REALLOC) begin
          moved_d   = 1'b1;
          copy_d    = ((res_q.hit_bytes < HDR) || (req_q < old_pay)) ? req_q : old_pay;
          old_off_d = res_q.hit_off;
          rescan_d  = 1'b1;
          state_d   = S_INJ;
        end else begin
          state_d = S_DONE;
        end
      end
      // Free: mark, then merge with a free previous and a free next block.
      S_FR1: begin
        cmd.kind     = CMD_UPD;
        cmd.free_en  = 1'b1;
        cmd.free_val = 1'b1;
        cmd.stamp_en = 1'b1;
        cmd.stamp    = stamp_q;
        stamp_d      = stamp_q + 1'b1;
        state_d      = S_FR2;
      end
      S_FR2: begin
        if (res_q.hit_prev_free) begin
          cmd.kind     = CMD_MERGE;
          cmd_idx      = idx_q - 1'b1;
          cmd.stamp_en = 1'b1;
          cmd.stamp    = stamp_q;
          stamp_d      = stamp_q + 1'b1;
          count_d      = count_q - 1'b1;
          idx_d        = idx_q - 1'b1;
        end
        state_d = S_FR3;
      end
      S_FR3: begin
        if (res_q.nxt_valid && res_q.nxt_free) begin
          cmd.kind     = CMD_MERGE;
          cmd.stamp_en = 1'b1;
          cmd.stamp    = stamp_q;
          stamp_d      = stamp_q + 1'b1;
          count_d      = count_q - 1'b1;
        end
        state_d = S_DONE;
      end
      // Shrink in place; a split tail joins a free next block.
      S_RA1: begin
        left_bytes = res_q.hit_bytes - need_q[DATA_W-1:0];
        split_ok   = (left_bytes >= MIN_TAIL) && (count_q < CNT_MAX);
        state_d    = S_DONE;
        if (split_ok) begin
          cmd.kind  = CMD_SPLIT;
          cmd.stamp = stamp_q;
          cmd.val   = need_q[DATA_W-1:0];
          stamp_d   = stamp_q + 1'b1;
          count_d   = count_q + 1'b1;
          if (res_q.nxt_valid && res_q.nxt_free) state_d = S_RA2;
        end
      end
      S_RA2: begin
        cmd.kind     = CMD_MERGE;
        cmd_idx      = idx_q + 1'b1;
        cmd.stamp_en = 1'b1;
        cmd.stamp    = stamp_q;
        stamp_d      = stamp_q + 1'b1;
        count_d      = count_q - 1'b1;
        state_d      = S_DONE;
      end
      // Grow into the free next block, then split off what is left when it is large enough.
      S_RB1: begin
        cmd.kind = CMD_MERGE;
        count_d  = count_q - 1'b1;
        state_d  = S_RB2;
      end
      S_RB2: begin
        left_bytes = sum17 - need_q[DATA_W-1:0];
        split_ok   = (({1'b0, sum17} < need_q) || (left_bytes >= MIN_TAIL)) &&
                     (count_q < CNT_MAX);
        if (split_ok) begin
          cmd.kind  = CMD_SPLIT;
          cmd.stamp = stamp_q;
          cmd.val   = need_q[DATA_W-1:0];
          stamp_d   = stamp_q + 1'b1;
          count_d   = count_q + 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= CNT_W'(1);
      stamp_q     <= STAMP_W'(1);
      rescan_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      stamp_q     <= stamp_d;
      rescan_q    <= rescan_d;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    req_q      <= req_d;
    h_q        <= h_d;
    rnd_q_q    <= rnd_q_d;
    need_q     <= need_d;
    res_q      <= res_d;
    res_hit_q  <= res_hit_d;
    res_best_q <= res_best_d;
    idx_q      <= idx_d;
    old_off_q  <= old_off_d;
    st_q       <= st_d;
    addr_q     <= addr_d;
    moved_q    <= moved_d;
    copy_q     <= copy_d;
    if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
      out_st_q    <= st_q;
      out_addr_q  <= addr_q;
      out_moved_q <= moved_q;
      out_copy_q  <= copy_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign address_o    = out_addr_q;
  assign moved_o      = out_moved_q;
  assign copy_bytes_o = out_copy_q;

endmodule
`default_nettype wire

[design/bfba_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Best-fit block allocator port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module bfba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [16:0] address_o,
  input logic        moved_o,
  input logic [16:0] copy_bytes_o
);
  import bfba_pkg::*;

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A failed request returns no address.
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (address_o == '0))
    else $error("failed request carries an address");

  // Only a successful reallocate moves a block.
  a_moved_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && moved_o |-> (status_o == ST_OK) && (address_o != '0))
    else $error("moved result without a valid address");

  // A copy length is reported only for a moved block.
  a_copy_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !moved_o |-> (copy_bytes_o == '0))
    else $error("copy length without a move");

  // A pool write and a request beat are never taken at the same edge.
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !(in_valid_i && !in_stall_o))
    else $error("request beat accepted during a pool write");

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .address_o       (address_o),
  .moved_o         (moved_o),
  .copy_bytes_o    (copy_bytes_o)
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit block allocator testbench
// Drives allocate, free and reallocate requests with random gaps and output
// stalls over several pool sizes, and checks every result beat against a
// cycle-free model of the block table kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb;
  import bfba_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HDR         = 16;
  localparam int unsigned ALIGN       = 8;
  localparam int unsigned MASK17      = 32'h1FFFF;
  localparam int unsigned SETTLE      = 200;

  // Table model and queue of expected result beats.
  class alloc_scoreboard;
    int unsigned offs   [TABLE_DEPTH];
    int unsigned sizes  [TABLE_DEPTH];
    bit          is_free[TABLE_DEPTH];
    int unsigned stamps [TABLE_DEPTH];
    int          count;
    int unsigned next_stamp;
    int unsigned pool;
    int          errors;
    status_e     exp_status[$];
    int unsigned exp_addr[$];
    bit          exp_moved[$];
    int unsigned exp_copy[$];

    function void configure(int unsigned bytes);
      pool = bytes & MASK17;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        offs[i] = 0; sizes[i] = 0; is_free[i] = 0; stamps[i] = 0;
      end
      sizes[0] = pool;
      is_free[0] = 1;
      count = 1;
      next_stamp = 1;
    endfunction

    function int unsigned take_stamp();
      take_stamp = next_stamp;
      next_stamp++;
    endfunction

    function void remove_at(int i);
      for (int j = i; j + 1 < count; j++) begin
        offs[j] = offs[j+1]; sizes[j] = sizes[j+1];
        is_free[j] = is_free[j+1]; stamps[j] = stamps[j+1];
      end
      count--;
    endfunction

    function void merge_next(int i);
      sizes[i] = (sizes[i] + sizes[i+1]) & MASK17;
      remove_at(i + 1);
    endfunction

    // Splits a free tail off block i at need when it is big enough and fits.
    function bit split_tail(int i, int unsigned need);
      int unsigned left;
      left = sizes[i] - need;
      if (left < HDR + ALIGN || count >= TABLE_DEPTH) return 0;
      for (int j = count; j > i + 1; j--) begin
        offs[j] = offs[j-1]; sizes[j] = sizes[j-1];
        is_free[j] = is_free[j-1]; stamps[j] = stamps[j-1];
      end
      count++;
      sizes[i] = need;
      offs[i+1] = (offs[i] + need) & MASK17;
      sizes[i+1] = left;
      is_free[i+1] = 1;
      stamps[i+1] = take_stamp();
      return 1;
    endfunction

    function int unsigned need_of(int unsigned req);
      return HDR + ALIGN * ((req + ALIGN - 1) / ALIGN);
    endfunction

    function int best_fit(int unsigned req);
      int unsigned need;
      int best;
      bit dummy;
      need = need_of(req);
      best = -1;
      for (int i = 0; i < count; i++) begin
        if (!is_free[i] || sizes[i] < need) continue;
        if (best < 0 || sizes[i] < sizes[best] ||
            (sizes[i] == sizes[best] && stamps[i] > stamps[best])) best = i;
      end
      if (best < 0) return -1;
      is_free[best] = 0;
      dummy = split_tail(best, need);
      return best;
    endfunction

    function void release_at(int i);
      is_free[i] = 1;
      stamps[i] = take_stamp();
      if (i > 0 && is_free[i-1]) begin
        merge_next(i - 1);
        i--;
        stamps[i] = take_stamp();
      end
      if (i + 1 < count && is_free[i+1]) begin
        merge_next(i);
        stamps[i] = take_stamp();
      end
    endfunction

    // Handle of a random listed block; mostly allocated ones.
    function int unsigned pick_handle(bit want_free);
      int idx[$];
      for (int i = 0; i < count; i++)
        if (is_free[i] == want_free) idx = {idx, i};
      if (idx.size() == 0) return 0;
      return (offs[idx[$urandom_range(idx.size()-1)]] + HDR) & MASK17;
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_request(func_e fn, int unsigned req, int unsigned h);
      status_e st;
      int unsigned addr, copy, need, old_off, old_pay;
      bit mv;
      int i, k;
      st = ST_OK; addr = 0; mv = 0; copy = 0;
      if (fn == FN_ALLOC) begin
        k = best_fit(req);
        if (k < 0) st = ST_NO_FIT;
        else addr = offs[k] + HDR;
      end else if (fn == FN_FREE || fn == FN_REALLOC) begin
        i = -1;
        for (int j = 0; j < count; j++)
          if (i < 0 && ((offs[j] + HDR) & MASK17) == h) i = j;
        if (h == 0) st = ST_NULL;
        else if (i < 0 || is_free[i]) st = ST_BAD_HANDLE;
        else if (fn == FN_FREE) release_at(i);
        else begin
          need = need_of(req);
          if (need <= sizes[i]) begin
            if (split_tail(i, need) && i + 2 < count && is_free[i+2]) begin
              merge_next(i + 1);
              stamps[i+1] = take_stamp();
            end
            addr = h;
          end else if (i + 1 < count && is_free[i+1] && sizes[i] + sizes[i+1] >= need) begin
            merge_next(i);
            void'(split_tail(i, need));
            addr = h;
          end else begin
            old_off = offs[i];
            old_pay = sizes[i] - HDR;
            k = best_fit(req);
            if (k < 0) st = ST_NO_FIT;
            else begin
              addr = offs[k] + HDR;
              mv = 1;
              copy = req < old_pay ? req : old_pay;
              for (i = 0; i < count; i++)
                if (offs[i] == old_off) break;
              if (i < count) release_at(i);
            end
          end
        end
      end
      exp_status = {exp_status, st};
      exp_addr = {exp_addr, addr & MASK17};
      exp_moved = {exp_moved, mv};
      exp_copy = {exp_copy, copy & MASK17};
    endfunction

    function void check_result(status_e st, int unsigned addr, bit mv, int unsigned copy);
      if (exp_status.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d address=%0d", $time, st, addr);
        errors++;
        return;
      end
      if (st != exp_status[0]) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_status[0], st);
        errors++;
      end
      if (addr != exp_addr[0]) begin
        $display("%0t: address expected %0d actual %0d", $time, exp_addr[0], addr);
        errors++;
      end
      if (mv != exp_moved[0]) begin
        $display("%0t: moved expected %0d actual %0d", $time, exp_moved[0], mv);
        errors++;
      end
      if (copy != exp_copy[0]) begin
        $display("%0t: copy_bytes expected %0d actual %0d", $time, exp_copy[0], copy);
        errors++;
      end
      void'(exp_status.pop_front());
      void'(exp_addr.pop_front());
      void'(exp_moved.pop_front());
      void'(exp_copy.pop_front());
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [16:0] pool_bytes_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [16:0] request_bytes_i = '0;
  logic [16:0] handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1;
  logic [1:0]  status_o;
  logic [16:0] address_o;
  logic        moved_o;
  logic [16:0] copy_bytes_o;

  alloc_scoreboard sb = new();

  best_fit_block_allocator uut (.*);

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall before each beat, then checks on acceptance.
  initial begin
    int stall_left;
    stall_left = $urandom_range(6);
    forever begin
      @(negedge clk_i);
      out_stall_i = (stall_left > 0);
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(status_e'(status_o), address_o, moved_o, copy_bytes_o);
        stall_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
    end
  end

  task automatic write_pool(int unsigned bytes);
    @(negedge clk_i);
    cfg_valid_i = 1;
    pool_bytes_i = bytes[16:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.configure(bytes);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  // Sends one request beat after a random gap and notes it when accepted.
  task automatic send_request(func_e fn, int unsigned req, int unsigned h);
    repeat ($urandom_range(6)) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1;
    func_i = fn;
    request_bytes_i = req[16:0];
    handle_i = h[16:0];
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(fn, req & MASK17, h & MASK17);
    @(negedge clk_i);
    in_valid_i = 0;
  endtask

  task automatic wait_idle();
    while (sb.exp_status.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One random request; small_mode favors tiny allocations to fill the table.
  task automatic random_request(bit small_mode);
    int unsigned pick, req, h;
    func_e fn;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) req = $urandom_range(65536);
    else if (small_mode) req = $urandom_range(24);
    else req = $urandom_range(600);
    if (pick < 45) fn = FN_ALLOC;
    else if (pick < 75) fn = FN_FREE;
    else if (pick < 96) fn = FN_REALLOC;
    else fn = FN_NONE;
    pick = $urandom_range(19);
    if (pick == 0) h = 0;
    else if (pick == 1) h = $urandom_range(MASK17);
    else if (pick == 2) h = sb.pick_handle(1);
    else h = sb.pick_handle(0);
    send_request(fn, req, h);
  endtask

  initial begin
    int unsigned a, b;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    sb.configure(RESET_POOL);

    // Directed part on the pool that comes up after reset.
    send_request(FN_ALLOC, 65536, 0);
    send_request(FN_NONE, MASK17, MASK17);
    send_request(FN_ALLOC, 0, 0);
    a = sb.exp_addr[$];
    send_request(FN_ALLOC, 1, 0);
    b = sb.exp_addr[$];
    send_request(FN_ALLOC, 100, 0);
    send_request(FN_FREE, 0, 0);
    send_request(FN_REALLOC, 40, 0);
    send_request(FN_FREE, 0, 5);
    send_request(FN_FREE, 0, MASK17);
    send_request(FN_FREE, 0, b);
    send_request(FN_FREE, 0, b);
    send_request(FN_REALLOC, 8, b);
    send_request(FN_REALLOC, 4, a);
    send_request(FN_REALLOC, 300, a);
    send_request(FN_REALLOC, 200, a);
    send_request(FN_ALLOC, 7, 0);
    send_request(FN_ALLOC, 65000, 0);
    send_request(FN_REALLOC, 65536, sb.pick_handle(0));
    send_request(FN_FREE, 0, sb.pick_handle(0));
    send_request(FN_ALLOC, 24, 0);

    // Random phases over several pool sizes, the extremes among them.
    repeat (200) random_request(0);
    wait_idle();
    write_pool(64);
    repeat (100) random_request(1);
    wait_idle();
    write_pool(65536);
    repeat (100) send_request(FN_ALLOC, $urandom_range(8), 0);
    repeat (150) random_request(1);
    wait_idle();
    write_pool($urandom_range(65536, 64));
    repeat (200) random_request(0);

    wait_idle();
    if (sb.errors == 0 && sb.exp_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
